@@ rtl/lspce_pkg.sv @@
// Shared types, constants and arithmetic steps of the LS pilot channel estimator.
package lspce_pkg;

   localparam int PILOT_SLOTS_DEF = 128;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;
   localparam int SPACING_W  = 6;
   localparam int START_W    = 11;
   localparam int LENGTH_W   = 12;
   localparam int INDEX_W    = 11;
   localparam int VALUE_W    = 16;
   localparam int SLOT_OUT_W = 7;
   localparam int EST_W      = 32;
   localparam int FE_REM_W   = SPACING_W + 1;
   localparam int FE_SLOT_W  = INDEX_W + 1;

   localparam int FE_DIV_STEPS  = INDEX_W;
   localparam int EST_DIV_STEPS = 33;
   localparam int MAG_DIV_STEPS = 64;
   localparam int SQRT_STEPS    = 32;
   localparam int BACK_STAGES   = MAG_DIV_STEPS + SQRT_STEPS;

   localparam int MID_DEPTH = 4;
   localparam int RSP_DEPTH = 2;

   localparam logic [SPACING_W-1:0] SPACING_RST = 6'd6;
   localparam logic [START_W-1:0]   A_START_RST = 11'd0;
   localparam logic [SPACING_W-1:0] A_PHASE_RST = 6'd3;
   localparam logic [START_W-1:0]   B_START_RST = 11'd1200;
   localparam logic [SPACING_W-1:0] B_PHASE_RST = 6'd0;
   localparam logic [LENGTH_W-1:0]  LENGTH_RST  = 12'd300;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PILOT_SPACING  = 3'd0,
      CSR_REGION_A_START = 3'd1,
      CSR_REGION_A_PHASE = 3'd2,
      CSR_REGION_B_START = 3'd3,
      CSR_REGION_B_PHASE = 3'd4,
      CSR_REGION_LENGTH  = 3'd5
   } csr_index_type;

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [INDEX_W-1:0]   addr;
      logic [VALUE_W-1:0]   re;
      logic [VALUE_W-1:0]   im;
   } mid_entry_type;

   typedef struct packed {
      logic          push;
      mid_entry_type entry;
   } mid_push_type;

   typedef struct packed {
      logic [SLOT_OUT_W-1:0] pilot_slot;
      logic [EST_W-1:0]      est_re;
      logic [EST_W-1:0]      est_im;
      logic [EST_W-1:0]      est_magnitude;
      logic                  zero_pilot;
   } rsp_entry_type;

   typedef struct packed {
      logic          push;
      rsp_entry_type entry;
   } rsp_push_type;

   typedef struct packed {
      logic                clearing;
   } back_status_type;

   typedef struct packed {
      logic                valid;
      op_type              op;
      logic [INDEX_W-1:0]  index;
      logic [VALUE_W-1:0]  re;
      logic [VALUE_W-1:0]  im;
      logic                in_a;
      logic                in_b;
      logic [INDEX_W-1:0]  dvd_a;
      logic [INDEX_W-1:0]  dvd_b;
      logic [FE_REM_W-1:0] rem_i;
      logic [FE_REM_W-1:0] rem_a;
      logic [FE_REM_W-1:0] rem_b;
      logic [INDEX_W-1:0]  q_a;
      logic [INDEX_W-1:0]  q_b;
   } fe_stage_type;

   typedef struct packed {
      logic                  valid;
      logic [SLOT_OUT_W-1:0] slot;
      logic                  zero;
      logic                  neg_re;
      logic                  neg_im;
      logic                  ovf_re;
      logic                  ovf_im;
      logic [31:0]           den;
      logic [47:0]           a_re;
      logic [47:0]           a_im;
      logic [32:0]           rem_re;
      logic [32:0]           q_re;
      logic [32:0]           rem_im;
      logic [32:0]           q_im;
      logic [31:0]           ymag2;
      logic [32:0]           rem_m;
      logic [63:0]           q_m;
      logic [63:0]           sq_v;
      logic [63:0]           sq_res;
   } back_stage_type;

   function automatic logic [FE_REM_W:0] fe_div_step(
      input logic [FE_REM_W-1:0]  rem,
      input logic                 b,
      input logic [SPACING_W-1:0] sp
   );
      logic [FE_REM_W-1:0] t;
      t = {rem[FE_REM_W-2:0], b};
      if (t >= {1'b0, sp}) begin
         return {t - {1'b0, sp}, 1'b1};
      end
      return {t, 1'b0};
   endfunction

   function automatic logic [33:0] div_step(
      input logic [32:0] rem,
      input logic        b,
      input logic [31:0] den
   );
      logic [32:0] t;
      t = {rem[31:0], b};
      if (t >= {1'b0, den}) begin
         return {t - {1'b0, den}, 1'b1};
      end
      return {t, 1'b0};
   endfunction

   function automatic back_stage_type back_div_stage(input back_stage_type p, input int j);
      back_stage_type r;
      logic [33:0]    s;
      logic           b;
      r = p;
      b = (j < 32) ? p.ymag2[31-j] : 1'b0;
      s = div_step(p.rem_m, b, p.den);
      r.rem_m = s[33:1];
      r.q_m = {p.q_m[62:0], s[0]};
      if (j < EST_DIV_STEPS) begin
         s = div_step(p.rem_re, p.a_re[32-j], p.den);
         r.rem_re = s[33:1];
         r.q_re = {p.q_re[31:0], s[0]};
         s = div_step(p.rem_im, p.a_im[32-j], p.den);
         r.rem_im = s[33:1];
         r.q_im = {p.q_im[31:0], s[0]};
      end
      if (j == MAG_DIV_STEPS - 1) begin
         r.sq_v = {p.q_m[62:0], s[0]};
         r.sq_res = '0;
      end
      return r;
   endfunction

   function automatic back_stage_type back_sqrt_stage(input back_stage_type p, input int j);
      back_stage_type r;
      logic [63:0]    bit_v;
      logic [63:0]    trial;
      r = p;
      bit_v = 64'd1 << (62 - 2 * j);
      trial = p.sq_res + bit_v;
      if (p.sq_v >= trial) begin
         r.sq_v = p.sq_v - trial;
         r.sq_res = (p.sq_res >> 1) + bit_v;
      end else begin
         r.sq_res = p.sq_res >> 1;
      end
      return r;
   endfunction

endpackage

@@ rtl/lspce_queue.sv @@
// Small first-in first-out queue of fixed-width transactions.
module lspce_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = lspce_pkg::MID_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == (PTR_W + 1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ((wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1)
                          : wr_ptr_ff;
      rd_ptr_in = do_pop ? ((rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1)
                         : rd_ptr_ff;
      count_in  = count_ff + (PTR_W + 1)'(do_push) - (PTR_W + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/lspce_front.sv @@
// Front end: configuration registers, pilot position classification and slot numbering.
module lspce_front #(
   parameter int PILOT_SLOTS = lspce_pkg::PILOT_SLOTS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [lspce_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lspce_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic                                req_mode,
   input  logic [lspce_pkg::INDEX_W-1:0]       req_index,
   input  logic signed [lspce_pkg::VALUE_W-1:0] req_value_re,
   input  logic signed [lspce_pkg::VALUE_W-1:0] req_value_im,
   input  lspce_pkg::back_status_type          back_status,
   input  logic                                mid_full,
   output lspce_pkg::mid_push_type             mid_push
);

   localparam int STEPS = lspce_pkg::FE_DIV_STEPS;
   localparam int IW    = lspce_pkg::INDEX_W;

   logic [lspce_pkg::SPACING_W-1:0] spacing_ff;
   logic [lspce_pkg::START_W-1:0]   a_start_ff;
   logic [lspce_pkg::SPACING_W-1:0] a_phase_ff;
   logic [lspce_pkg::START_W-1:0]   b_start_ff;
   logic [lspce_pkg::SPACING_W-1:0] b_phase_ff;
   logic [lspce_pkg::LENGTH_W-1:0]  length_ff;

   lspce_pkg::fe_stage_type fe_ff [STEPS+1];
   lspce_pkg::fe_stage_type fe_in [STEPS+1];
   lspce_pkg::mid_push_type cls_ff, cls_in;
   lspce_pkg::fe_stage_type last;

   logic                           front_adv;
   logic                           accept;
   logic                           pilot_a;
   logic                           pilot_b;
   logic                           keep;
   logic [lspce_pkg::FE_SLOT_W-1:0] slot;

   assign front_adv = !(cls_ff.push && mid_full);
   assign req_full  = !front_adv || back_status.clearing;
   assign accept    = req_push && !req_full;

   assign mid_push.push  = front_adv && cls_ff.push;
   assign mid_push.entry = cls_ff.entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         spacing_ff <= lspce_pkg::SPACING_RST;
         a_start_ff <= lspce_pkg::A_START_RST;
         a_phase_ff <= lspce_pkg::A_PHASE_RST;
         b_start_ff <= lspce_pkg::B_START_RST;
         b_phase_ff <= lspce_pkg::B_PHASE_RST;
         length_ff  <= lspce_pkg::LENGTH_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            lspce_pkg::CSR_PILOT_SPACING:  spacing_ff <= csr_wdata[lspce_pkg::SPACING_W-1:0];
            lspce_pkg::CSR_REGION_A_START: a_start_ff <= csr_wdata[lspce_pkg::START_W-1:0];
            lspce_pkg::CSR_REGION_A_PHASE: a_phase_ff <= csr_wdata[lspce_pkg::SPACING_W-1:0];
            lspce_pkg::CSR_REGION_B_START: b_start_ff <= csr_wdata[lspce_pkg::START_W-1:0];
            lspce_pkg::CSR_REGION_B_PHASE: b_phase_ff <= csr_wdata[lspce_pkg::SPACING_W-1:0];
            lspce_pkg::CSR_REGION_LENGTH:  length_ff  <= csr_wdata[lspce_pkg::LENGTH_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      fe_in[0]       = fe_ff[0];
      fe_in[0].valid = accept;
      fe_in[0].op    = lspce_pkg::op_type'(req_mode);
      fe_in[0].index = req_index;
      fe_in[0].re    = req_value_re;
      fe_in[0].im    = req_value_im;
      fe_in[0].dvd_a = req_index - a_start_ff;
      fe_in[0].dvd_b = req_index - b_start_ff;
      fe_in[0].in_a  = (req_index >= a_start_ff) &&
                       ({1'b0, req_index - a_start_ff} < length_ff);
      fe_in[0].in_b  = (req_index >= b_start_ff) &&
                       ({1'b0, req_index - b_start_ff} < length_ff);
      fe_in[0].rem_i = '0;
      fe_in[0].rem_a = '0;
      fe_in[0].rem_b = '0;
      fe_in[0].q_a   = '0;
      fe_in[0].q_b   = '0;
   end

   for (genvar s = 1; s <= STEPS; s++) begin : g_div
      logic [lspce_pkg::FE_REM_W:0] st_i;
      logic [lspce_pkg::FE_REM_W:0] st_a;
      logic [lspce_pkg::FE_REM_W:0] st_b;
      always_comb begin
         st_i = lspce_pkg::fe_div_step(fe_ff[s-1].rem_i, fe_ff[s-1].index[IW-s], spacing_ff);
         st_a = lspce_pkg::fe_div_step(fe_ff[s-1].rem_a, fe_ff[s-1].dvd_a[IW-s], spacing_ff);
         st_b = lspce_pkg::fe_div_step(fe_ff[s-1].rem_b, fe_ff[s-1].dvd_b[IW-s], spacing_ff);
         fe_in[s]       = fe_ff[s-1];
         fe_in[s].rem_i = st_i[lspce_pkg::FE_REM_W:1];
         fe_in[s].rem_a = st_a[lspce_pkg::FE_REM_W:1];
         fe_in[s].rem_b = st_b[lspce_pkg::FE_REM_W:1];
         fe_in[s].q_a   = {fe_ff[s-1].q_a[IW-2:0], st_a[0]};
         fe_in[s].q_b   = {fe_ff[s-1].q_b[IW-2:0], st_b[0]};
      end
   end

   always_comb begin
      last    = fe_ff[STEPS];
      pilot_a = (spacing_ff != '0) && last.in_a && (last.rem_i == {1'b0, a_phase_ff});
      pilot_b = (spacing_ff != '0) && last.in_b && (last.rem_i == {1'b0, b_phase_ff});
      slot    = pilot_a ? {last.q_a, 1'b0} : {last.q_b, 1'b1};
      cls_in.entry.op = last.op;
      cls_in.entry.re = last.re;
      cls_in.entry.im = last.im;
      if (last.op == lspce_pkg::OP_LOAD) begin
         keep              = last.index < IW'(PILOT_SLOTS);
         cls_in.entry.addr = last.index;
      end else begin
         keep              = (pilot_a || pilot_b) &&
                             (slot < lspce_pkg::FE_SLOT_W'(PILOT_SLOTS));
         cls_in.entry.addr = slot[IW-1:0];
      end
      cls_in.push = last.valid && keep;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= STEPS; i++) begin
            fe_ff[i].valid <= 1'b0;
         end
         cls_ff.push <= 1'b0;
      end else if (front_adv) begin
         fe_ff  <= fe_in;
         cls_ff <= cls_in;
      end
   end

endmodule

@@ rtl/lspce_back.sv @@
// Back end: pilot table, least-squares estimate, divide and square-root pipeline.
module lspce_back #(
   parameter int PILOT_SLOTS = lspce_pkg::PILOT_SLOTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          mid_empty,
   input  lspce_pkg::mid_entry_type      mid_entry,
   output logic                          mid_pop,
   input  logic                          rsp_full,
   output lspce_pkg::rsp_push_type       rsp_push,
   output lspce_pkg::back_status_type    status
);

   localparam int SLOT_W = (PILOT_SLOTS > 1) ? $clog2(PILOT_SLOTS) : 1;
   localparam int NST    = lspce_pkg::BACK_STAGES;
   localparam int DIVS   = lspce_pkg::MAG_DIV_STEPS;

   logic [31:0] table_mem [PILOT_SLOTS];

   logic              clearing_ff;
   logic [SLOT_W-1:0] clr_addr_ff;
   logic              adv;

   logic [31:0]       rd_data_ff;
   logic              rd_valid_ff;
   logic [6:0]        rd_slot_ff;
   logic signed [15:0] rd_yr_ff, rd_yi_ff;

   logic               mul_valid_ff;
   logic [6:0]         mul_slot_ff;
   logic signed [31:0] p_rr_ff, p_ii_ff, p_ir_ff, p_ri_ff;
   logic signed [31:0] p_xr_ff, p_xi_ff, p_yr_ff, p_yi_ff;

   logic               sum_valid_ff;
   logic [6:0]         sum_slot_ff;
   logic signed [32:0] sum_nr_ff, sum_ni_ff;
   logic [31:0]        sum_den_ff, sum_ymag2_ff;

   logic [31:0] abs_re, abs_im;

   lspce_pkg::back_stage_type pipe_ff [NST+1];
   lspce_pkg::back_stage_type pipe_in [NST+1];

   logic                     out_valid_ff;
   lspce_pkg::rsp_entry_type out_ff, out_in;
   lspce_pkg::back_stage_type fin;

   assign adv             = !(out_valid_ff && rsp_full);
   assign mid_pop         = adv && !mid_empty && !clearing_ff;
   assign status.clearing = clearing_ff;
   assign rsp_push.push   = adv && out_valid_ff;
   assign rsp_push.entry  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clearing_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == SLOT_W'(PILOT_SLOTS - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         table_mem[clr_addr_ff] <= '0;
      end else if (mid_pop && mid_entry.op == lspce_pkg::OP_LOAD) begin
         table_mem[mid_entry.addr[SLOT_W-1:0]] <= {mid_entry.re, mid_entry.im};
      end
      if (mid_pop) begin
         rd_data_ff <= table_mem[mid_entry.addr[SLOT_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rd_slot_ff <= 7'(mid_entry.addr);
         rd_yr_ff   <= mid_entry.re;
         rd_yi_ff   <= mid_entry.im;
         p_rr_ff    <= rd_yr_ff * $signed(rd_data_ff[31:16]);
         p_ii_ff    <= rd_yi_ff * $signed(rd_data_ff[15:0]);
         p_ir_ff    <= rd_yi_ff * $signed(rd_data_ff[31:16]);
         p_ri_ff    <= rd_yr_ff * $signed(rd_data_ff[15:0]);
         p_xr_ff    <= $signed(rd_data_ff[31:16]) * $signed(rd_data_ff[31:16]);
         p_xi_ff    <= $signed(rd_data_ff[15:0]) * $signed(rd_data_ff[15:0]);
         p_yr_ff    <= rd_yr_ff * rd_yr_ff;
         p_yi_ff    <= rd_yi_ff * rd_yi_ff;
         mul_slot_ff  <= rd_slot_ff;
         sum_nr_ff    <= 33'(p_rr_ff) + 33'(p_ii_ff);
         sum_ni_ff    <= 33'(p_ir_ff) - 33'(p_ri_ff);
         sum_den_ff   <= 32'(p_xr_ff) + 32'(p_xi_ff);
         sum_ymag2_ff <= 32'(p_yr_ff) + 32'(p_yi_ff);
         sum_slot_ff  <= mul_slot_ff;
      end
   end

   always_comb begin
      abs_re = sum_nr_ff[32] ? 32'(-sum_nr_ff) : sum_nr_ff[31:0];
      abs_im = sum_ni_ff[32] ? 32'(-sum_ni_ff) : sum_ni_ff[31:0];
      pipe_in[0]        = pipe_ff[0];
      pipe_in[0].valid  = sum_valid_ff;
      pipe_in[0].slot   = sum_slot_ff;
      pipe_in[0].den    = sum_den_ff;
      pipe_in[0].zero   = (sum_den_ff == '0);
      pipe_in[0].neg_re = sum_nr_ff[32];
      pipe_in[0].neg_im = sum_ni_ff[32];
      pipe_in[0].a_re   = {abs_re, 16'd0} + 48'(sum_den_ff >> 1);
      pipe_in[0].a_im   = {abs_im, 16'd0} + 48'(sum_den_ff >> 1);
      pipe_in[0].ovf_re = 32'(pipe_in[0].a_re[47:33]) >= sum_den_ff;
      pipe_in[0].ovf_im = 32'(pipe_in[0].a_im[47:33]) >= sum_den_ff;
      pipe_in[0].rem_re = 33'(pipe_in[0].a_re[47:33]);
      pipe_in[0].rem_im = 33'(pipe_in[0].a_im[47:33]);
      pipe_in[0].q_re   = '0;
      pipe_in[0].q_im   = '0;
      pipe_in[0].ymag2  = sum_ymag2_ff;
      pipe_in[0].rem_m  = '0;
      pipe_in[0].q_m    = '0;
      pipe_in[0].sq_v   = '0;
      pipe_in[0].sq_res = '0;
   end

   for (genvar s = 1; s <= NST; s++) begin : g_stage
      if (s <= DIVS) begin : g_div
         always_comb begin
            pipe_in[s] = lspce_pkg::back_div_stage(pipe_ff[s-1], s - 1);
         end
      end else begin : g_sqrt
         always_comb begin
            pipe_in[s] = lspce_pkg::back_sqrt_stage(pipe_ff[s-1], s - 1 - DIVS);
         end
      end
   end

   always_comb begin
      fin = pipe_ff[NST];
      out_in.pilot_slot = fin.slot;
      out_in.zero_pilot = fin.zero;
      if (fin.zero) begin
         out_in.est_re = '0;
      end else if (fin.neg_re) begin
         out_in.est_re = (fin.ovf_re || fin.q_re > 33'h080000000) ? 32'h80000000
                                                                   : 32'(-fin.q_re);
      end else begin
         out_in.est_re = (fin.ovf_re || fin.q_re > 33'h07FFFFFFF) ? 32'h7FFFFFFF
                                                                   : fin.q_re[31:0];
      end
      if (fin.zero) begin
         out_in.est_im = '0;
      end else if (fin.neg_im) begin
         out_in.est_im = (fin.ovf_im || fin.q_im > 33'h080000000) ? 32'h80000000
                                                                   : 32'(-fin.q_im);
      end else begin
         out_in.est_im = (fin.ovf_im || fin.q_im > 33'h07FFFFFFF) ? 32'h7FFFFFFF
                                                                   : fin.q_im[31:0];
      end
      if (fin.zero) begin
         out_in.est_magnitude = '0;
      end else begin
         out_in.est_magnitude = (fin.sq_res > 64'h0FFFFFFFF) ? 32'hFFFFFFFF
                                                             : fin.sq_res[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff  <= 1'b0;
         mul_valid_ff <= 1'b0;
         sum_valid_ff <= 1'b0;
         for (int i = 0; i <= NST; i++) begin
            pipe_ff[i].valid <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         rd_valid_ff  <= mid_pop && (mid_entry.op == lspce_pkg::OP_SAMPLE);
         mul_valid_ff <= rd_valid_ff;
         sum_valid_ff <= mul_valid_ff;
         pipe_ff      <= pipe_in;
         out_valid_ff <= pipe_ff[NST].valid;
         out_ff       <= out_in;
      end
   end

endmodule

@@ rtl/ls_pilot_channel_estimator_top.sv @@
// Top level of the least-squares OFDM pilot channel estimator.
// Takes one subcarrier sample or pilot-table load per clock while req_full is low and
// returns one channel estimate per clock, while the result queue has room, for each pilot
// sample in the table; samples off the pilot grid and loads give no result. A front end
// (an 11-step pipelined divide by the pilot spacing) numbers the pilot slot, then a
// 4-entry queue feeds the back end (table read, products, 64-step pipelined divide,
// 32-step pipelined square root). Either side stalls on its own through the queue and a
// 2-entry result queue. After reset the pilot table is cleared one slot per cycle, and
// req_full stays high until the clearing is done; configuration writes are taken throughout.
module ls_pilot_channel_estimator_top #(
   parameter int PILOT_SLOTS = lspce_pkg::PILOT_SLOTS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [lspce_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lspce_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic                                 req_mode,
   input  logic [lspce_pkg::INDEX_W-1:0]        req_index,
   input  logic signed [lspce_pkg::VALUE_W-1:0] req_value_re,
   input  logic signed [lspce_pkg::VALUE_W-1:0] req_value_im,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic [lspce_pkg::SLOT_OUT_W-1:0]     rsp_pilot_slot,
   output logic signed [lspce_pkg::EST_W-1:0]   rsp_est_re,
   output logic signed [lspce_pkg::EST_W-1:0]   rsp_est_im,
   output logic [lspce_pkg::EST_W-1:0]          rsp_est_magnitude,
   output logic                                 rsp_zero_pilot
);

   localparam int MID_W = $bits(lspce_pkg::mid_entry_type);
   localparam int RSP_W = $bits(lspce_pkg::rsp_entry_type);

   lspce_pkg::mid_push_type    mid_push;
   lspce_pkg::back_status_type back_status;
   lspce_pkg::rsp_push_type    rsp_push;
   lspce_pkg::rsp_entry_type   rsp_head;

   logic             mid_full;
   logic             mid_empty;
   logic             mid_pop;
   logic [MID_W-1:0] mid_head;
   logic             rsp_full;
   logic [RSP_W-1:0] rsp_head_bits;

   lspce_front #(
      .PILOT_SLOTS(PILOT_SLOTS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_mode     (req_mode),
      .req_index    (req_index),
      .req_value_re (req_value_re),
      .req_value_im (req_value_im),
      .back_status  (back_status),
      .mid_full     (mid_full),
      .mid_push     (mid_push)
   );

   lspce_queue #(
      .WIDTH(MID_W),
      .DEPTH(lspce_pkg::MID_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push.push),
      .push_data (mid_push.entry),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_head),
      .empty     (mid_empty)
   );

   lspce_back #(
      .PILOT_SLOTS(PILOT_SLOTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_entry (lspce_pkg::mid_entry_type'(mid_head)),
      .mid_pop   (mid_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .status    (back_status)
   );

   lspce_queue #(
      .WIDTH(RSP_W),
      .DEPTH(lspce_pkg::RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push.push),
      .push_data (rsp_push.entry),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_head_bits),
      .empty     (rsp_empty)
   );

   assign rsp_head          = lspce_pkg::rsp_entry_type'(rsp_head_bits);
   assign rsp_pilot_slot    = rsp_head.pilot_slot;
   assign rsp_est_re        = rsp_head.est_re;
   assign rsp_est_im        = rsp_head.est_im;
   assign rsp_est_magnitude = rsp_head.est_magnitude;
   assign rsp_zero_pilot    = rsp_head.zero_pilot;

endmodule

@@ rtl/lspce_checker.sv @@
// Port-level checks of the pilot channel estimator, bound to its top level.
module lspce_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_full,
   input logic                                 rsp_empty,
   input logic                                 rsp_pop,
   input logic [lspce_pkg::SLOT_OUT_W-1:0]     rsp_pilot_slot,
   input logic signed [lspce_pkg::EST_W-1:0]   rsp_est_re,
   input logic signed [lspce_pkg::EST_W-1:0]   rsp_est_im,
   input logic [lspce_pkg::EST_W-1:0]          rsp_est_magnitude,
   input logic                                 rsp_zero_pilot
);

   a_full_after_reset: assert property (@(posedge clock) reset |=> req_full)
      else $error("input side open right after reset");

   a_empty_after_reset: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result shown right after reset");

   a_zero_pilot_fields: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_zero_pilot |->
         rsp_est_re == '0 && rsp_est_im == '0 && rsp_est_magnitude == '0)
      else $error("zero pilot result with nonzero estimate");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_pilot_slot) &&
         $stable(rsp_est_re) && $stable(rsp_est_im) && $stable(rsp_est_magnitude) &&
         $stable(rsp_zero_pilot))
      else $error("waiting result transaction changed");

endmodule

bind ls_pilot_channel_estimator_top lspce_checker u_checker (.*);
